// ===== rtl/apng_pkg.sv =====
// Shared types, constants and the arctangent table for the arc polyline node generator.
// No dependencies; used by apng_mul, apng_cordic and the top level by scoped names.
`timescale 1ns / 1ps
package apng_pkg;

	localparam int MAX_SEGMENTS      = 63;
	localparam int CORDIC_ITERATIONS = 16;
	localparam int ATAN_ENTRIES      = 24;

	localparam int SEG_W  = 6;
	localparam int CW     = 34;
	localparam int ZW     = 19;
	localparam int AT_W   = 17;
	localparam int ANG_W  = 18;
	localparam int KW     = $clog2(ATAN_ENTRIES);
	localparam int ITER_N = (CORDIC_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_ITERATIONS;
	localparam int PROD_W = 16 + CW;
	localparam int ACC_W  = 39;
	localparam int STEP_SH = 38;
	localparam int STEP_W = PROD_W - STEP_SH;

	localparam logic [SEG_W-1:0] MAX_SEG_V = SEG_W'(MAX_SEGMENTS);
	localparam logic [KW-1:0]    K_LAST    = KW'(ITER_N - 1);
	localparam logic [ANG_W-1:0] PI_Q16      = 18'd205887;
	localparam logic [ANG_W-1:0] HALF_PI_Q16 = 18'd102944;
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
	localparam logic [2:0] REG_STEP_LENGTH   = 3'd2;
	localparam logic [2:0] REG_BASE_ANGLE    = 3'd3;
	localparam logic [2:0] REG_SEGMENT_COUNT = 3'd4;

	typedef logic signed [CW-1:0] cvec_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cordic_stat_t;

	function automatic logic [AT_W-1:0] atan_q16(input logic [KW-1:0] k);
		logic [AT_W-1:0] v;
		case (k)
			5'd0:    v = 17'd51472;
			5'd1:    v = 17'd30386;
			5'd2:    v = 17'd16055;
			5'd3:    v = 17'd8150;
			5'd4:    v = 17'd4091;
			5'd5:    v = 17'd2047;
			5'd6:    v = 17'd1024;
			5'd7:    v = 17'd512;
			5'd8:    v = 17'd256;
			5'd9:    v = 17'd128;
			5'd10:   v = 17'd64;
			5'd11:   v = 17'd32;
			5'd12:   v = 17'd16;
			5'd13:   v = 17'd8;
			5'd14:   v = 17'd4;
			5'd15:   v = 17'd2;
			5'd16:   v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/apng_mul.sv =====
// Shared sign-magnitude multiplier: unsigned 16-bit factor times a signed vector.
// Registers the product magnitude and the result sign. Depends on apng_pkg.
`timescale 1ns / 1ps
module apng_mul (
	input  logic                         clk,
	input  logic                         go,
	input  logic [15:0]                  a,
	input  apng_pkg::cvec_t              b,
	input  logic                         flip,
	output logic [apng_pkg::PROD_W-1:0]  prod,
	output logic                         neg
);

	logic [apng_pkg::CW-1:0] mag;

	assign mag = b[apng_pkg::CW-1] ? apng_pkg::CW'(-b) : apng_pkg::CW'(b);

	always_ff @(posedge clk) begin
		if (go) begin
			prod <= apng_pkg::PROD_W'(a) * apng_pkg::PROD_W'(mag);
			neg  <= b[apng_pkg::CW-1] ^ flip;
		end
	end

endmodule

// ===== rtl/apng_cordic.sv =====
// Iterative shift-add CORDIC rotator, one micro-rotation per cycle.
// Produces cos (x) and sin (y) in Q1.30 for a Q1.16 angle in [0, pi/2]. Depends on apng_pkg.
`timescale 1ns / 1ps
module apng_cordic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [apng_pkg::ZW-1:0]   z_init,
	output apng_pkg::cordic_stat_t           stat,
	output apng_pkg::cvec_t                  x,
	output apng_pkg::cvec_t                  y
);

	logic [apng_pkg::KW-1:0]         k_q;
	logic                            busy_q;
	logic                            done_q;
	apng_pkg::cvec_t                 x_q;
	apng_pkg::cvec_t                 y_q;
	logic signed [apng_pkg::ZW-1:0]  z_q;
	apng_pkg::cvec_t                 xs;
	apng_pkg::cvec_t                 ys;
	logic signed [apng_pkg::ZW-1:0]  at;

	assign xs = x_q >>> k_q;
	assign ys = y_q >>> k_q;
	assign at = signed'({{(apng_pkg::ZW - apng_pkg::AT_W){1'b0}}, apng_pkg::atan_q16(k_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			k_q    <= '0;
		end else if (busy_q) begin
			busy_q <= (k_q != apng_pkg::K_LAST);
			done_q <= (k_q == apng_pkg::K_LAST);
			k_q    <= k_q + 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= apng_pkg::CORDIC_GAIN_Q30;
			y_q <= '0;
			z_q <= z_init;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign x = x_q;
	assign y = y_q;

endmodule

// ===== rtl/arc_polyline_node_generator_core.sv =====
// Top level: configuration registers, node sequencer and output register.
// Depends on apng_pkg, apng_mul and apng_cordic.
`timescale 1ns / 1ps
// One bend transaction yields segment_count + 1 node transactions (63 segments at most),
// starting with the origin; the final node carries last. The block takes no new bend until
// the final node has been taken. Each segment has an angle setup step, then runs the CORDIC
// rotator until it is done, makes two passes through the shared multiplier (sine, then
// cosine step) and ends in the output state. Configuration is to be written through
// cfg_we / cfg_index / cfg_data only while idle; the block itself does not enforce this.
module arc_polyline_node_generator_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  bend,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  node_x,
	output logic signed [15:0]  node_y,
	output logic [5:0]          node_index,
	output logic                last
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PROD  = 3'd1;
	localparam logic [2:0] S_EMIT  = 3'd2;
	localparam logic [2:0] S_ANGLE = 3'd3;
	localparam logic [2:0] S_ROT   = 3'd4;
	localparam logic [2:0] S_SIN   = 3'd5;
	localparam logic [2:0] S_COS   = 3'd6;

	logic [11:0]                     origin_x_q;
	logic [11:0]                     origin_y_q;
	logic [15:0]                     step_length_q;
	logic [15:0]                     base_angle_q;
	logic [apng_pkg::SEG_W-1:0]      segment_count_q;

	logic [2:0]                      state_q;
	logic                            out_valid_q;
	logic                            bneg_q;
	logic                            fold_q;
	logic [apng_pkg::SEG_W-1:0]      n_q;
	logic [31:0]                     a_q;
	logic [apng_pkg::ACC_W-1:0]      acc_q;
	logic [15:0]                     x_q;
	logic [15:0]                     y_q;
	logic [apng_pkg::SEG_W-1:0]      idx_q;
	logic                            last_q;

	logic                            in_acc;
	logic [15:0]                     bmag;
	logic [apng_pkg::SEG_W-1:0]      n_clamp;

	logic                            mul_go;
	logic [15:0]                     mul_a;
	apng_pkg::cvec_t                 mul_b;
	logic                            mul_flip;
	logic [apng_pkg::PROD_W-1:0]     prod;
	logic                            prod_neg;
	logic [15:0]                     step;

	logic [apng_pkg::ACC_W-15:0]     mag_full;
	logic [apng_pkg::ANG_W-1:0]      mag_c;
	logic                            fold;
	logic [apng_pkg::ANG_W-1:0]      m;
	logic signed [apng_pkg::ZW-1:0]  z_init;

	apng_pkg::cordic_stat_t          cst;
	apng_pkg::cvec_t                 cx;
	apng_pkg::cvec_t                 cy;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q      <= 12'd0;
			origin_y_q      <= 12'd0;
			step_length_q   <= 16'd2560;
			base_angle_q    <= 16'd6434;
			segment_count_q <= 6'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				apng_pkg::REG_ORIGIN_X:      origin_x_q      <= cfg_data[11:0];
				apng_pkg::REG_ORIGIN_Y:      origin_y_q      <= cfg_data[11:0];
				apng_pkg::REG_STEP_LENGTH:   step_length_q   <= cfg_data;
				apng_pkg::REG_BASE_ANGLE:    base_angle_q    <= cfg_data;
				apng_pkg::REG_SEGMENT_COUNT: segment_count_q <= cfg_data[apng_pkg::SEG_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign bmag     = bend[15] ? 16'(-bend) : 16'(bend);
	assign n_clamp  = (segment_count_q > apng_pkg::MAX_SEG_V) ? apng_pkg::MAX_SEG_V
	                                                         : segment_count_q;

	// angle of segment i: ((2i+1) * base * |bend|) >> 14, clamped to pi, folded to [0, pi/2]
	assign mag_full = acc_q[apng_pkg::ACC_W-1:14];
	assign mag_c    = (mag_full > (apng_pkg::ACC_W-14)'(apng_pkg::PI_Q16)) ? apng_pkg::PI_Q16
	                                                                     : mag_full[apng_pkg::ANG_W-1:0];
	assign fold     = (mag_c > apng_pkg::HALF_PI_Q16);
	assign m        = fold ? (apng_pkg::PI_Q16 - mag_c) : mag_c;
	assign z_init   = signed'({1'b0, m});

	always_comb begin
		mul_go   = 1'b0;
		mul_a    = step_length_q;
		mul_b    = cy;
		mul_flip = bneg_q;
		case (state_q)
			S_IDLE: begin
				mul_go   = in_acc;
				mul_a    = base_angle_q;
				mul_b    = apng_pkg::cvec_t'({{(apng_pkg::CW - 16){1'b0}}, bmag});
				mul_flip = 1'b0;
			end
			S_ROT: begin
				mul_go = cst.done;
			end
			S_SIN: begin
				mul_go   = 1'b1;
				mul_b    = cx;
				mul_flip = fold_q;
			end
			default: ;
		endcase
	end

	apng_mul u_mul (
		.clk  (clk),
		.go   (mul_go),
		.a    (mul_a),
		.b    (mul_b),
		.flip (mul_flip),
		.prod (prod),
		.neg  (prod_neg)
	);

	apng_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_ANGLE),
		.z_init (z_init),
		.stat   (cst),
		.x      (cx),
		.y      (cy)
	);

	// truncated step magnitude, sign applied afterwards
	assign step = prod_neg
		? 16'(-{{(16 - apng_pkg::STEP_W){1'b0}}, prod[apng_pkg::PROD_W-1:apng_pkg::STEP_SH]})
		: {{(16 - apng_pkg::STEP_W){1'b0}}, prod[apng_pkg::PROD_W-1:apng_pkg::STEP_SH]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= S_PROD;
				end
				S_PROD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= last_q ? S_IDLE : S_ANGLE;
					end
				end
				S_ANGLE: state_q <= S_ROT;
				S_ROT: begin
					if (cst.done) state_q <= S_SIN;
				end
				S_SIN: state_q <= S_COS;
				S_COS: begin
					out_valid_q <= 1'b1;
					state_q     <= S_EMIT;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					bneg_q <= bend[15];
					n_q    <= n_clamp;
					x_q    <= {4'd0, origin_x_q};
					y_q    <= {4'd0, origin_y_q};
					idx_q  <= '0;
				end
			end
			S_PROD: begin
				a_q    <= prod[31:0];
				acc_q  <= apng_pkg::ACC_W'(prod[31:0]);
				last_q <= (n_q == '0);
			end
			S_ANGLE: begin
				fold_q <= fold;
				acc_q  <= acc_q + apng_pkg::ACC_W'({a_q, 1'b0});
			end
			S_SIN: x_q <= x_q + step;
			S_COS: begin
				y_q    <= y_q - step;
				idx_q  <= idx_q + 1'b1;
				last_q <= ((idx_q + 1'b1) == n_q);
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign node_x     = signed'(x_q);
	assign node_y     = signed'(y_q);
	assign node_index = idx_q;
	assign last       = last_q;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_PROD)
		else $error("accepted bend did not start a curve");
	a_valid_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_EMIT)
		else $error("node shown outside output state");
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> node_index <= n_q)
		else $error("node index beyond segment count");
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> node_index == n_q)
		else $error("last flag on wrong node");
	a_cordic_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cst.busy |-> state_q == S_ROT)
		else $error("rotator busy outside rotation state");
`endif

endmodule

// ===== tb/sv/arc_polyline_node_checker.sv =====
// Checker for arc_polyline_node_generator_core: mirrors the register writes, predicts the
// nodes of every accepted bend transaction and compares each accepted node transaction.
// Depends on apng_pkg.
`timescale 1ns / 1ps
module arc_polyline_node_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] bend,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] node_x,
	input  logic signed [15:0] node_y,
	input  logic [5:0]         node_index,
	input  logic               last,
	output int                 mismatches,
	output int                 nodes_pending
);

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [5:0]         index;
		logic               last;
	} polyline_node_t;

	longint arctan_q16 [apng_pkg::ATAN_ENTRIES] = '{
		51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2,
		1, 0, 0, 0, 0, 0, 0, 0
	};

	logic [11:0]    org_x;
	logic [11:0]    org_y;
	logic [15:0]    chord_len;
	logic [15:0]    half_angle;
	logic [5:0]     seg_count;
	polyline_node_t pending_nodes [$];
	polyline_node_t want;
	int             fail_count;

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("%0t mismatch: %s got %0d expected %0d", $time, what, got, exp_val);
		fail_count++;
	endtask

	// quadrant fold then shift-add rotation; results in Q1.30
	function automatic void sin_cos_q30(input longint ang, output longint s, output longint c);
		longint m;
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		bit     neg;
		bit     fold;
		neg  = ang < 0;
		m    = neg ? -ang : ang;
		fold = m > longint'(apng_pkg::HALF_PI_Q16);
		if (fold)
			m = longint'(apng_pkg::PI_Q16) - m;
		x = longint'(apng_pkg::CORDIC_GAIN_Q30);
		y = 0;
		z = m;
		for (int k = 0; k < apng_pkg::ITER_N; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - arctan_q16[k];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + arctan_q16[k];
			end
		end
		s = neg ? -y : y;
		c = fold ? -x : x;
	endfunction

	// chord length times a Q1.30 value, down to pixels, truncated toward zero
	function automatic int scaled_step(input longint v);
		longint unsigned mag;
		longint unsigned p;
		mag = (v < 0) ? -v : v;
		p   = (64'(chord_len) * mag) >> apng_pkg::STEP_SH;
		return (v < 0) ? -int'(p) : int'(p);
	endfunction

	function automatic void predict_curve(input logic [15:0] raw);
		polyline_node_t  nd;
		longint unsigned bmag;
		longint unsigned mag;
		longint          ang;
		longint          s;
		longint          c;
		int              px;
		int              py;
		int unsigned     n;
		bit              neg;
		neg  = raw[15];
		bmag = neg ? 64'h10000 - 64'(raw) : 64'(raw);
		n    = seg_count;
		if (n > apng_pkg::MAX_SEGMENTS)
			n = apng_pkg::MAX_SEGMENTS;
		px       = int'(org_x);
		py       = int'(org_y);
		nd.x     = px[15:0];
		nd.y     = py[15:0];
		nd.index = '0;
		nd.last  = (n == 0);
		pending_nodes.insert(pending_nodes.size(), nd);
		for (int unsigned i = 0; i < n; i++) begin
			mag = (64'(2 * i + 1) * 64'(half_angle) * bmag) >> 14;
			if (mag > 64'(apng_pkg::PI_Q16))
				mag = 64'(apng_pkg::PI_Q16);
			ang = neg ? -longint'(mag) : longint'(mag);
			sin_cos_q30(ang, s, c);
			px       = px + scaled_step(s);
			py       = py - scaled_step(c);
			nd.x     = px[15:0];
			nd.y     = py[15:0];
			nd.index = 6'(i + 1);
			nd.last  = (i + 1 == n);
			pending_nodes.insert(pending_nodes.size(), nd);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x      = '0;
			org_y      = '0;
			chord_len  = 16'd2560;
			half_angle = 16'd6434;
			seg_count  = 6'd8;
			pending_nodes.delete();
			fail_count = 0;
			mismatches    <= 0;
			nodes_pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				predict_curve(bend);
			if (out_valid && !out_stall) begin
				if (pending_nodes.size() == 0) begin
					report_mismatch("node transaction with none pending, index", node_index, -1);
				end else begin
					want = pending_nodes.pop_front();
					if (node_x !== want.x)
						report_mismatch($sformatf("node %0d x", want.index), node_x, want.x);
					if (node_y !== want.y)
						report_mismatch($sformatf("node %0d y", want.index), node_y, want.y);
					if (node_index !== want.index)
						report_mismatch("node_index", node_index, want.index);
					if (last !== want.last)
						report_mismatch($sformatf("node %0d last", want.index), last, want.last);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					apng_pkg::REG_ORIGIN_X:      org_x = cfg_data[11:0];
					apng_pkg::REG_ORIGIN_Y:      org_y = cfg_data[11:0];
					apng_pkg::REG_STEP_LENGTH:   chord_len = cfg_data;
					apng_pkg::REG_BASE_ANGLE:    half_angle = cfg_data;
					apng_pkg::REG_SEGMENT_COUNT: seg_count = cfg_data[5:0];
					default: ;
				endcase
			end
			mismatches    <= fail_count;
			nodes_pending <= pending_nodes.size();
		end
	end

endmodule

// ===== tb/sv/tb_arc_polyline_node_generator_core.sv =====
// Top of the arc polyline node generator testbench: clock, reset, register setup,
// bend stimulus, output stall and verdict. Depends on apng_pkg, the core and the checker.
`timescale 1ns / 1ps
module tb_arc_polyline_node_generator_core;

	localparam int QUIET_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_BENDS = 112;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] bend;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] node_x;
	logic signed [15:0] node_y;
	logic [5:0]         node_index;
	logic               last;
	int                 mismatches;
	int                 nodes_pending;

	int tx_idle_pct  = 29;
	int rx_idle_pct  = 67;
	int quiet_cycles = 0;
	int hold_left    = 0;
	bit hold_request = 1'b0;

	logic [15:0] corner_bends [9] = '{
		16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000,
		16'h0001, 16'hFFFF, 16'h2000, 16'hE000
	};
	logic [2:0] reg_order [5] = '{
		apng_pkg::REG_ORIGIN_X, apng_pkg::REG_ORIGIN_Y, apng_pkg::REG_STEP_LENGTH,
		apng_pkg::REG_BASE_ANGLE, apng_pkg::REG_SEGMENT_COUNT
	};

	arc_polyline_node_generator_core dut (.*);
	arc_polyline_node_checker checker_inst (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// output side: random stall, or a long hold-off when requested
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic offer_bend(input logic [15:0] v);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct && gap < 20)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		bend     <= v;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (nodes_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// writes all five registers, then a write to an unused index that must be ignored
	task automatic program_curve(input logic [15:0] ox, oy, len, ang, segs);
		logic [15:0] vals [5];
		vals = '{ox, oy, len, ang, segs};
		for (int r = 0; r < 5; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= reg_order[r];
			cfg_data  <= vals[r];
			@(posedge clk);
		end
		cfg_index <= 3'(apng_pkg::REG_SEGMENT_COUNT + 1 + $urandom_range(2));
		cfg_data  <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int          sent;
		int          burst;
		int          pick;
		logic [15:0] segs;
		logic [15:0] ang;
		logic [15:0] v;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= apng_pkg::REG_ORIGIN_X;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		bend      <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, corner bends
		foreach (corner_bends[i])
			offer_bend(corner_bends[i]);

		// all registers at their top, upper data bits set
		wait_idle();
		program_curve(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		offer_bend(16'h4000);
		offer_bend(16'hC000);
		offer_bend(16'h0000);
		offer_bend(16'h04D2);

		// zero segments: origin only
		wait_idle();
		program_curve(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		offer_bend(16'h0000);
		offer_bend(16'h4000);

		// angles past a quarter turn take the folded path
		wait_idle();
		program_curve(16'd100, 16'd200, 16'd2560, 16'd40000, 16'd3);
		offer_bend(16'h4000);
		offer_bend(16'hC000);
		offer_bend(16'd12000);

		sent = 0;
		while (sent < RANDOM_BENDS) begin
			wait_idle();
			pick = $urandom_range(19);
			if (pick == 0)
				segs = {10'($urandom), 6'd0};
			else if (pick == 1)
				segs = {10'($urandom), 6'($urandom_range(40, 63))};
			else
				segs = {10'($urandom), 6'($urandom_range(1, 12))};
			ang = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(12000));
			program_curve(16'($urandom), 16'($urandom), 16'($urandom), ang, segs);
			burst = $urandom_range(4, 12);
			for (int j = 0; j < burst && sent < RANDOM_BENDS; j++) begin
				tx_idle_pct = (sent < RANDOM_BENDS / 3) ? 29 :
				              (sent < 2 * RANDOM_BENDS / 3) ? 67 : 0;
				rx_idle_pct = (sent < RANDOM_BENDS / 3) ? 67 :
				              (sent < 2 * RANDOM_BENDS / 3) ? 29 : 0;
				if (sent == 15)
					hold_request = 1'b1;
				pick = $urandom_range(9);
				if (pick < 7)
					v = 16'(int'($urandom_range(32768)) - 16384);
				else if (pick < 9)
					v = 16'($urandom);
				else
					case ($urandom_range(3))
						0:       v = 16'h4000;
						1:       v = 16'hC000;
						2:       v = 16'h8000;
						default: v = 16'h7FFF;
					endcase
				offer_bend(v);
				sent++;
			end
		end

		wait_idle();
		repeat (30) @(posedge clk);
		if (mismatches == 0 && nodes_pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/apng_pkg.sv
rtl/apng_mul.sv
rtl/apng_cordic.sv
rtl/arc_polyline_node_generator_core.sv
tb/sv/arc_polyline_node_checker.sv
tb/sv/tb_arc_polyline_node_generator_core.sv
